FILE: src/guest_page_table_walker_macros.svh
`ifndef GUEST_PAGE_TABLE_WALKER_MACROS_SVH
`define GUEST_PAGE_TABLE_WALKER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GPTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define GPTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/gptw_pkg.sv
`default_nettype none

package gptw_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WALK = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // input transaction kinds
  localparam logic REQ_NEW  = 1'b0;
  localparam logic REQ_RESP = 1'b1;

  // result transaction kinds
  localparam logic [1:0] KIND_RD   = 2'd0;
  localparam logic [1:0] KIND_WR   = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // completion status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISALIGN = 3'd1;
  localparam logic [2:0] ST_MODE     = 3'd2;
  localparam logic [2:0] ST_NOT_PRES = 3'd3;
  localparam logic [2:0] ST_MEM_ERR  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_CR0  = 2'd0;
  localparam logic [1:0] REG_CR3  = 2'd1;
  localparam logic [1:0] REG_CR4  = 2'd2;
  localparam logic [1:0] REG_EFER = 2'd3;

  localparam int CR0_PG    = 31;
  localparam int CR4_PAE   = 5;
  localparam int CR4_LA57  = 12;
  localparam int EFER_LMA  = 10;
  localparam int PTE_P     = 0;
  localparam int PTE_PS    = 7;

  localparam logic [2:0] LVL_PML4 = 3'd4;
  localparam logic [2:0] LVL_PDPT = 3'd3;
  localparam logic [2:0] LVL_PD   = 3'd2;
  localparam logic [2:0] LVL_PT   = 3'd1;
  localparam logic [2:0] LVL_NONE = 3'd0;

  // 9-bit table index of a linear address at a walk level
  function automatic logic [8:0] tbl_index(input logic [63:0] addr, input logic [2:0] lvl);
    logic [1:0] sel;
    sel = 2'(lvl - 3'd1);
    unique case (sel)
      2'd3: tbl_index = addr[47:39];
      2'd2: tbl_index = addr[38:30];
      2'd1: tbl_index = addr[29:21];
      2'd0: tbl_index = addr[20:12];
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: src/gptw_req_if.sv
`default_nettype none

interface gptw_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] linear_address;
  logic        is_write;
  logic [63:0] write_data;
  logic [63:0] read_data;
  logic        mem_ok;

  modport source (
    output valid, kind, linear_address, is_write, write_data, read_data, mem_ok,
    input  ready
  );
  modport sink (
    input  valid, kind, linear_address, is_write, write_data, read_data, mem_ok,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/gptw_rsp_if.sv
`default_nettype none

interface gptw_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [51:0] phys_address;
  logic [63:0] store_data;
  logic [63:0] read_value;
  logic [2:0]  status;

  modport source (
    output valid, out_kind, phys_address, store_data, read_value, status,
    input  ready
  );
  modport sink (
    input  valid, out_kind, phys_address, store_data, read_value, status,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/guest_page_table_walker.sv
// a result transaction sits in the output register in the cycle after its input
// throughput: one input transaction per cycle while the output is not stalled; all
// decode is combinational between the input handshake and the output register
// input is stalled only while the output register is full and not being drained
// rst_n is synchronous, active low: clears the walk state, output valid and the
// four guest registers
`default_nettype none

module guest_page_table_walker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gptw_req_if.sink         in_chan,
  gptw_rsp_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

`include "guest_page_table_walker_macros.svh"

  logic [63:0] cr0_r, cr3_r, cr4_r, efer_r;

  gptw_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  level_r, level_nxt;
  logic [63:0] saddr_r, saddr_nxt;
  logic        swrite_r, swrite_nxt;
  logic [63:0] sdata_r, sdata_nxt;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [51:0] out_pa_r;
  logic [63:0] out_sd_r;
  logic [63:0] out_rv_r;
  logic [2:0]  out_st_r;

  logic        acc;
  logic        cfg_wr;
  logic        mode_ok;
  logic        busy;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [51:0] res_pa;
  logic [63:0] res_sd;
  logic [63:0] res_rv;
  logic [2:0]  res_st;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[4:3])
      gptw_pkg::REG_CR0:  prdata = cr0_r;
      gptw_pkg::REG_CR3:  prdata = cr3_r;
      gptw_pkg::REG_CR4:  prdata = cr4_r;
      gptw_pkg::REG_EFER: prdata = efer_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr0_r  <= '0;
      cr3_r  <= '0;
      cr4_r  <= '0;
      efer_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        gptw_pkg::REG_CR0:  cr0_r  <= pwdata;
        gptw_pkg::REG_CR3:  cr3_r  <= pwdata;
        gptw_pkg::REG_CR4:  cr4_r  <= pwdata;
        gptw_pkg::REG_EFER: efer_r <= pwdata;
      endcase
    end
  end

  // handshake
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign acc = in_chan.valid && in_chan.ready;

  assign mode_ok = cr0_r[gptw_pkg::CR0_PG] && cr4_r[gptw_pkg::CR4_PAE] &&
                   efer_r[gptw_pkg::EFER_LMA] && !cr4_r[gptw_pkg::CR4_LA57];
  assign busy = (phase_r == gptw_pkg::PH_WALK) || (phase_r == gptw_pkg::PH_DATA);

  // per-transaction decode
  always_comb begin
    phase_nxt  = phase_r;
    level_nxt  = level_r;
    saddr_nxt  = saddr_r;
    swrite_nxt = swrite_r;
    sdata_nxt  = sdata_r;
    res_valid  = 1'b0;
    res_kind   = gptw_pkg::KIND_RD;
    res_pa     = '0;
    res_sd     = '0;
    res_rv     = '0;
    res_st     = gptw_pkg::ST_OK;

    if (acc) begin
      if (in_chan.kind == gptw_pkg::REQ_NEW) begin
        if (!busy) begin
          saddr_nxt  = in_chan.linear_address;
          swrite_nxt = in_chan.is_write;
          sdata_nxt  = in_chan.write_data;
          res_valid  = 1'b1;
          priority if (in_chan.linear_address[2:0] != 3'd0) begin
            res_kind  = gptw_pkg::KIND_DONE;
            res_st    = gptw_pkg::ST_MISALIGN;
            phase_nxt = gptw_pkg::PH_IDLE;
            level_nxt = gptw_pkg::LVL_NONE;
          end else if (!mode_ok) begin
            res_kind  = gptw_pkg::KIND_DONE;
            res_st    = gptw_pkg::ST_MODE;
            phase_nxt = gptw_pkg::PH_IDLE;
            level_nxt = gptw_pkg::LVL_NONE;
          end else begin
            phase_nxt = gptw_pkg::PH_WALK;
            level_nxt = gptw_pkg::LVL_PML4;
            res_pa    = {cr3_r[51:12],
                         gptw_pkg::tbl_index(in_chan.linear_address, gptw_pkg::LVL_PML4),
                         3'b000};
          end
        end
      end else begin
        unique case (phase_r)
          gptw_pkg::PH_DATA: begin
            res_valid = 1'b1;
            res_kind  = gptw_pkg::KIND_DONE;
            res_st    = in_chan.mem_ok ? gptw_pkg::ST_OK : gptw_pkg::ST_MEM_ERR;
            res_rv    = (in_chan.mem_ok && !swrite_r) ? in_chan.read_data : 64'd0;
            phase_nxt = gptw_pkg::PH_IDLE;
            level_nxt = gptw_pkg::LVL_NONE;
          end
          gptw_pkg::PH_WALK: begin
            res_valid = 1'b1;
            priority if (!in_chan.mem_ok) begin
              res_kind  = gptw_pkg::KIND_DONE;
              res_st    = gptw_pkg::ST_MEM_ERR;
              phase_nxt = gptw_pkg::PH_IDLE;
              level_nxt = gptw_pkg::LVL_NONE;
            end else if (!in_chan.read_data[gptw_pkg::PTE_P]) begin
              res_kind  = gptw_pkg::KIND_DONE;
              res_st    = gptw_pkg::ST_NOT_PRES;
              phase_nxt = gptw_pkg::PH_IDLE;
              level_nxt = gptw_pkg::LVL_NONE;
            end else if (level_r == gptw_pkg::LVL_PDPT &&
                         in_chan.read_data[gptw_pkg::PTE_PS]) begin
              phase_nxt = gptw_pkg::PH_DATA;
              res_kind  = swrite_r ? gptw_pkg::KIND_WR : gptw_pkg::KIND_RD;
              res_sd    = swrite_r ? sdata_r : 64'd0;
              res_pa    = {in_chan.read_data[51:30], saddr_r[29:0]};
            end else if (level_r == gptw_pkg::LVL_PD &&
                         in_chan.read_data[gptw_pkg::PTE_PS]) begin
              phase_nxt = gptw_pkg::PH_DATA;
              res_kind  = swrite_r ? gptw_pkg::KIND_WR : gptw_pkg::KIND_RD;
              res_sd    = swrite_r ? sdata_r : 64'd0;
              res_pa    = {in_chan.read_data[51:21], saddr_r[20:0]};
            end else if (level_r <= gptw_pkg::LVL_PT) begin
              phase_nxt = gptw_pkg::PH_DATA;
              res_kind  = swrite_r ? gptw_pkg::KIND_WR : gptw_pkg::KIND_RD;
              res_sd    = swrite_r ? sdata_r : 64'd0;
              res_pa    = {in_chan.read_data[51:12], saddr_r[11:0]};
            end else begin
              level_nxt = level_r - 3'd1;
              res_pa    = {in_chan.read_data[51:12],
                           gptw_pkg::tbl_index(saddr_r, level_r - 3'd1),
                           3'b000};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= gptw_pkg::PH_IDLE;
      level_r  <= gptw_pkg::LVL_NONE;
      saddr_r  <= '0;
      swrite_r <= 1'b0;
      sdata_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      saddr_r  <= saddr_nxt;
      swrite_r <= swrite_nxt;
      sdata_r  <= sdata_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      out_kind_r <= res_kind;
      out_pa_r   <= res_pa;
      out_sd_r   <= res_sd;
      out_rv_r   <= res_rv;
      out_st_r   <= res_st;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_kind     = out_kind_r;
  assign out_chan.phys_address = out_pa_r;
  assign out_chan.store_data   = out_sd_r;
  assign out_chan.read_value   = out_rv_r;
  assign out_chan.status       = out_st_r;

  `GPTW_ASSERT_NOW(a_walk_level_range, phase_r == gptw_pkg::PH_WALK,
    level_r >= gptw_pkg::LVL_PT && level_r <= gptw_pkg::LVL_PML4)
  `GPTW_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_chan.ready, !in_chan.ready)
  `GPTW_ASSERT_NEXT(a_idle_request_answered,
    acc && in_chan.kind == gptw_pkg::REQ_NEW && phase_r == gptw_pkg::PH_IDLE, out_valid_r)
  `GPTW_ASSERT_NEXT(a_done_returns_idle, acc && res_valid && res_kind == gptw_pkg::KIND_DONE,
    phase_r == gptw_pkg::PH_IDLE && level_r == gptw_pkg::LVL_NONE)
  `GPTW_ASSERT_NOW(a_request_status_ok, out_valid_r && out_kind_r != gptw_pkg::KIND_DONE,
    out_st_r == gptw_pkg::ST_OK)

endmodule

`default_nettype wire

FILE: dv/guest_page_table_walker_tb.sv
`timescale 1ns / 1ps

module guest_page_table_walker_tb;

  localparam logic [63:0] FRAME_4K = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] FRAME_1G = 64'h000F_FFFF_C000_0000;
  localparam logic [63:0] FRAME_2M = 64'h000F_FFFF_FFE0_0000;
  localparam logic [63:0] OFFS_1G  = 64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] OFFS_2M  = 64'h0000_0000_001F_FFFF;
  localparam logic [63:0] OFFS_4K  = 64'h0000_0000_0000_0FFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_COUNT = 13;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic        kind;
    logic [63:0] linear_address;
    logic        is_write;
    logic [63:0] write_data;
    logic [63:0] read_data;
    logic        mem_ok;
  } walk_req_t;

  typedef struct {
    logic [1:0]  out_kind;
    logic [51:0] phys_address;
    logic [63:0] store_data;
    logic [63:0] read_value;
    logic [2:0]  status;
  } walk_rsp_t;

  class walk_tracker;
    logic [63:0]      cr0, cr3, cr4, efer;
    gptw_pkg::phase_t walk_phase;
    logic [2:0]       level;
    logic [63:0]      addr;
    logic             wr;
    logic [63:0]      wdata;
    walk_rsp_t        outputs_due[$];
    int               errors;

    function new();
      cr0 = '0;
      cr3 = '0;
      cr4 = '0;
      efer = '0;
      walk_phase = gptw_pkg::PH_IDLE;
      level = gptw_pkg::LVL_NONE;
      addr = '0;
      wr = 1'b0;
      wdata = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        gptw_pkg::REG_CR0:  cr0 = value;
        gptw_pkg::REG_CR3:  cr3 = value;
        gptw_pkg::REG_CR4:  cr4 = value;
        gptw_pkg::REG_EFER: efer = value;
        default: ;
      endcase
    endfunction

    function bit busy();
      return walk_phase == gptw_pkg::PH_WALK || walk_phase == gptw_pkg::PH_DATA;
    endfunction

    function void queue_output(logic [1:0] k, logic [63:0] pa, logic [63:0] sd,
                               logic [63:0] rv, logic [2:0] st);
      walk_rsp_t r;
      r.out_kind = k;
      r.phys_address = pa[51:0];
      r.store_data = sd;
      r.read_value = rv;
      r.status = st;
      outputs_due.push_back(r);
    endfunction

    function void complete(logic [2:0] st, logic [63:0] rv);
      queue_output(gptw_pkg::KIND_DONE, '0, '0, rv, st);
      walk_phase = gptw_pkg::PH_IDLE;
      level = gptw_pkg::LVL_NONE;
    endfunction

    function void table_read(logic [63:0] base);
      int lv;
      int sh;
      logic [63:0] ix;
      lv = level;
      sh = 12 + 9 * ((lv - 1) & 3);
      ix = (addr >> sh) & 64'h1FF;
      queue_output(gptw_pkg::KIND_RD, (base & FRAME_4K) + (ix << 3), '0, '0,
                   gptw_pkg::ST_OK);
    endfunction

    function void data_access(logic [63:0] pa);
      walk_phase = gptw_pkg::PH_DATA;
      if (wr) queue_output(gptw_pkg::KIND_WR, pa, wdata, '0, gptw_pkg::ST_OK);
      else queue_output(gptw_pkg::KIND_RD, pa, '0, '0, gptw_pkg::ST_OK);
    endfunction

    // returns 1 when the transaction causes an output
    function bit take_input(walk_req_t it);
      logic [63:0] e;
      e = it.read_data;
      if (it.kind == gptw_pkg::REQ_NEW) begin
        if (busy()) return 1'b0;
        addr = it.linear_address;
        wr = it.is_write;
        wdata = it.write_data;
        if (addr[2:0] != 3'b000) begin
          complete(gptw_pkg::ST_MISALIGN, '0);
          return 1'b1;
        end
        if (!cr0[gptw_pkg::CR0_PG] || !cr4[gptw_pkg::CR4_PAE] ||
            !efer[gptw_pkg::EFER_LMA] || cr4[gptw_pkg::CR4_LA57]) begin
          complete(gptw_pkg::ST_MODE, '0);
          return 1'b1;
        end
        walk_phase = gptw_pkg::PH_WALK;
        level = gptw_pkg::LVL_PML4;
        table_read(cr3);
        return 1'b1;
      end
      if (walk_phase == gptw_pkg::PH_DATA) begin
        if (!it.mem_ok) complete(gptw_pkg::ST_MEM_ERR, '0);
        else complete(gptw_pkg::ST_OK, wr ? 64'd0 : e);
        return 1'b1;
      end
      if (walk_phase != gptw_pkg::PH_WALK) return 1'b0;
      if (!it.mem_ok) begin
        complete(gptw_pkg::ST_MEM_ERR, '0);
        return 1'b1;
      end
      if (!e[gptw_pkg::PTE_P]) begin
        complete(gptw_pkg::ST_NOT_PRES, '0);
        return 1'b1;
      end
      if (level == gptw_pkg::LVL_PDPT && e[gptw_pkg::PTE_PS]) begin
        data_access((e & FRAME_1G) | (addr & OFFS_1G));
        return 1'b1;
      end
      if (level == gptw_pkg::LVL_PD && e[gptw_pkg::PTE_PS]) begin
        data_access((e & FRAME_2M) | (addr & OFFS_2M));
        return 1'b1;
      end
      if (level <= gptw_pkg::LVL_PT) begin
        data_access((e & FRAME_4K) | (addr & OFFS_4K));
        return 1'b1;
      end
      level = level - 3'd1;
      table_read(e);
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_output(walk_rsp_t got);
      walk_rsp_t want;
      if (outputs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected output kind %0d pa %h",
                                  got.out_kind, got.phys_address));
        return;
      end
      want = outputs_due.pop_front();
      if (got.out_kind !== want.out_kind)
        report_mismatch($sformatf("out_kind %0d, want %0d", got.out_kind, want.out_kind));
      if (got.phys_address !== want.phys_address)
        report_mismatch($sformatf("phys_address %h, want %h",
                                  got.phys_address, want.phys_address));
      if (got.store_data !== want.store_data)
        report_mismatch($sformatf("store_data %h, want %h", got.store_data, want.store_data));
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  gptw_req_if req_bus ();
  gptw_rsp_if rsp_bus ();

  walk_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int idle_cycles;

  guest_page_table_walker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (rsp_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic walk_req_t mk(logic k, logic [63:0] a, logic w, logic [63:0] wd,
                                   logic [63:0] rd, logic ok);
    walk_req_t it;
    it.kind = k;
    it.linear_address = a;
    it.is_write = w;
    it.write_data = wd;
    it.read_data = rd;
    it.mem_ok = ok;
    return it;
  endfunction

  // mostly well-formed walks with random content, some stray transactions
  function automatic walk_req_t random_item();
    walk_req_t it;
    it = mk(gptw_pkg::REQ_NEW, rand64(), 1'($urandom_range(1)), rand64(), rand64(),
            $urandom_range(99) < 95);
    if (!tracker.busy()) begin
      it.kind = ($urandom_range(99) < 5) ? gptw_pkg::REQ_RESP : gptw_pkg::REQ_NEW;
      if ($urandom_range(99) < 90) it.linear_address[2:0] = 3'b000;
    end else begin
      it.kind = ($urandom_range(99) < 4) ? gptw_pkg::REQ_NEW : gptw_pkg::REQ_RESP;
      if (tracker.walk_phase == gptw_pkg::PH_WALK) begin
        it.read_data[gptw_pkg::PTE_P] = $urandom_range(99) < 92;
        it.read_data[gptw_pkg::PTE_PS] = $urandom_range(99) < 30;
      end
    end
    return it;
  endfunction

  function automatic void set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 33;
        recv_idle_pct = 72;
      end
      1: begin
        send_idle_pct = 72;
        recv_idle_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  task automatic send(input walk_req_t it, output bit caused);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid          <= 1'b1;
    req_bus.kind           <= it.kind;
    req_bus.linear_address <= it.linear_address;
    req_bus.is_write       <= it.is_write;
    req_bus.write_data     <= it.write_data;
    req_bus.read_data      <= it.read_data;
    req_bus.mem_ok         <= it.mem_ok;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    caused = tracker.take_input(it);
  endtask

  task automatic send_item(input walk_req_t it);
    bit caused;
    send(it, caused);
  endtask

  task automatic run_items(input int n);
    for (int count = 0; count < n; count++) begin
      send_item(random_item());
    end
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (tracker.outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write, then read back the same register
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.write_reg(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== value)
      tracker.report_mismatch($sformatf("reg %0d reads %h, want %h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [63:0] c0, input logic [63:0] c3,
                           input logic [63:0] c4, input logic [63:0] ef);
    write_reg(gptw_pkg::REG_CR0, c0);
    write_reg(gptw_pkg::REG_CR3, c3);
    write_reg(gptw_pkg::REG_CR4, c4);
    write_reg(gptw_pkg::REG_EFER, ef);
  endtask

  task automatic directed();
    logic [63:0] pg, pae, lma, ps;
    pg  = 64'd1 << gptw_pkg::CR0_PG;
    pae = 64'd1 << gptw_pkg::CR4_PAE;
    lma = 64'd1 << gptw_pkg::EFER_LMA;
    ps  = 64'd1 << gptw_pkg::PTE_PS;
    // registers at reset: response while idle, then paging off
    send_item(mk(gptw_pkg::REQ_RESP, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, 1'b1));
    send_item(mk(gptw_pkg::REQ_NEW, 64'd0, 1'b0, 64'd0, 64'd0, 1'b1));
    drain();
    // five-level paging set
    write_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(mk(gptw_pkg::REQ_NEW, 64'd8, 1'b0, 64'd0, 64'd0, 1'b1));
    drain();
    write_all(pg, ALL_ONES, pae, lma);
    send_item(mk(gptw_pkg::REQ_NEW, 64'd7, 1'b1, ALL_ONES, 64'd0, 1'b0));
    // full 4 KiB walk, large bit at pml4 ignored
    send_item(mk(gptw_pkg::REQ_NEW, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 64'd0, 64'd0, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, 64'd1, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, 64'd1, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b1));
    // 1 GiB write, response data ignored
    send_item(mk(gptw_pkg::REQ_NEW, 64'd0, 1'b1, ALL_ONES, 64'd0, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, 64'd1, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b1));
    // 2 MiB read, failed data access
    send_item(mk(gptw_pkg::REQ_NEW, rand64() & ~64'h7, 1'b0, 64'd0, 64'd0, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, 64'd1, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, 64'd1, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0,
                 64'd1 | ps | (64'd1 << 40), 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b0));
    // failed table read
    send_item(mk(gptw_pkg::REQ_NEW, 64'h0000_7FFF_FFFF_FFF8, 1'b1, rand64(), 64'd0, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES, 1'b0));
    // request while busy, then not-present entry
    send_item(mk(gptw_pkg::REQ_NEW, 64'h1000, 1'b0, 64'd0, 64'd0, 1'b1));
    send_item(mk(gptw_pkg::REQ_NEW, 64'h2000, 1'b1, ALL_ONES, 64'd0, 1'b1));
    send_item(mk(gptw_pkg::REQ_RESP, 64'd0, 1'b0, 64'd0, ALL_ONES & ~64'd1, 1'b1));
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int hold_left;
    walk_rsp_t seen;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
        seen.out_kind = rsp_bus.out_kind;
        seen.phys_address = rsp_bus.phys_address;
        seen.store_data = rsp_bus.store_data;
        seen.read_value = rsp_bus.read_value;
        seen.status = rsp_bus.status;
        tracker.compare_output(seen);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  initial begin
    logic [63:0] c0, c3, c4, ef;
    tracker = new();
    idle_cycles = 0;
    hold_request = 0;
    set_idling(0);
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    req_bus.valid          <= 1'b0;
    req_bus.kind           <= gptw_pkg::REQ_NEW;
    req_bus.linear_address <= '0;
    req_bus.is_write       <= 1'b0;
    req_bus.write_data     <= '0;
    req_bus.read_data      <= '0;
    req_bus.mem_ok         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_idling(ph < 4 ? 0 : (ph < 9 ? 1 : 2));
      c0 = rand64() | (64'd1 << gptw_pkg::CR0_PG);
      c3 = rand64();
      c4 = (rand64() | (64'd1 << gptw_pkg::CR4_PAE)) & ~(64'd1 << gptw_pkg::CR4_LA57);
      ef = rand64() | (64'd1 << gptw_pkg::EFER_LMA);
      case (ph)
        0: c3 = '0;
        1: c3 = ALL_ONES;
        3: c0[gptw_pkg::CR0_PG] = 1'b0;
        5: c4[gptw_pkg::CR4_PAE] = 1'b0;
        7: ef[gptw_pkg::EFER_LMA] = 1'b0;
        9: c4[gptw_pkg::CR4_LA57] = 1'b1;
        default: ;
      endcase
      write_all(c0, c3, c4, ef);
      if (ph == 10) hold_request = 300;
      if (ph == 6) begin
        run_items(PHASE_ITEMS / 2);
        drain();
        run_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_items(PHASE_ITEMS);
      end
      drain();
    end

    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
